FILE: rtl/aalhp_pkg.sv
`default_nettype none
package aalhp_pkg;

    localparam int WINDOW_BYTES_DEF = 16;
    localparam int DIV_STEPS = 27;
    localparam logic [26:0] DURATION_NUM = 27'd92160000;
    localparam logic [23:0] DEFAULT_RATE = 24'd44100;
    localparam logic [32:0] PTS_WRAP_MASK = 33'h1_FFFF_FFFF;
    localparam logic [7:0] ADTS_SYNC0 = 8'hFF;
    localparam logic [7:0] LATM_SYNC0 = 8'h56;
    localparam logic [4:0] AOT_ESCAPE = 5'd31;
    localparam logic [3:0] RATE_IDX_EXPLICIT = 4'hF;
    localparam logic CFG_START_MODE = 1'b0;
    localparam logic CFG_DETECT_MODE = 1'b1;

    typedef struct packed {
        logic accept;
        logic check;
        logic div_step;
        logic load;
        logic shift;
    } cmd_t;

    typedef struct packed {
        logic need_check;
        logic match;
        logic div_done;
        logic out_free;
        logic drop_last;
    } stat_t;

    function automatic logic [23:0] rate_lookup(input logic [3:0] idx);
        logic [23:0] r;
        case (idx)
            4'd0: r = 24'd96000;
            4'd1: r = 24'd88200;
            4'd2: r = 24'd64000;
            4'd3: r = 24'd48000;
            4'd4: r = 24'd44100;
            4'd5: r = 24'd32000;
            4'd6: r = 24'd24000;
            4'd7: r = 24'd22050;
            4'd8: r = 24'd16000;
            4'd9: r = 24'd12000;
            4'd10: r = 24'd11025;
            4'd11: r = 24'd8000;
            4'd12: r = 24'd7350;
            default: r = 24'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/aalhp_ctrl.sv
`default_nettype none
module aalhp_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire aalhp_pkg::stat_t stat,
    output aalhp_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_LOAD,
        ST_DROP
    } state_t;

    state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && stat.need_check) state_reg <= ST_CHECK;
                end
                ST_CHECK: state_reg <= stat.match ? ST_DIV : ST_DROP;
                ST_DIV: begin
                    if (stat.div_done) state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    if (stat.out_free) state_reg <= ST_DROP;
                end
                ST_DROP: begin
                    if (stat.drop_last) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready     = (state_reg == ST_IDLE);
    assign cmd.accept   = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.check    = (state_reg == ST_CHECK);
    assign cmd.div_step = (state_reg == ST_DIV) && !stat.div_done;
    assign cmd.load     = (state_reg == ST_LOAD) && stat.out_free;
    assign cmd.shift    = (state_reg == ST_DROP);

endmodule
`default_nettype wire

FILE: rtl/aalhp_dpath.sv
`default_nettype none
module aalhp_dpath #(
    parameter int WINDOW_BYTES = aalhp_pkg::WINDOW_BYTES_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_we,
    input  wire logic [0:0]      cfg_index,
    input  wire logic [0:0]      cfg_data,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_pts_load,
    input  wire logic [32:0]     in_pts_value,
    input  wire aalhp_pkg::cmd_t cmd,
    output aalhp_pkg::stat_t     stat,
    input  wire logic            m_tready,
    output logic                 m_tvalid,
    output logic [13:0]          out_frame_bytes,
    output logic [23:0]          out_sample_rate,
    output logic [3:0]           out_channel_config,
    output logic [32:0]          out_frame_pts,
    output logic [26:0]          out_frame_duration,
    output logic                 out_is_latm
);

    localparam int IW = $clog2(WINDOW_BYTES);
    localparam int FW = $clog2(WINDOW_BYTES + 1);
    localparam logic [FW-1:0] FILL_LAST = FW'(WINDOW_BYTES - 1);
    localparam logic [13:0] WIN14 = 14'(WINDOW_BYTES);

    logic [7:0]    win_reg [WINDOW_BYTES];
    logic [FW-1:0] fill_reg;
    logic [13:0]   skip_reg;
    logic          mode_reg;
    logic          detect_reg;
    logic          configured_reg;
    logic [23:0]   rate_reg;
    logic [3:0]    chan_reg;
    logic [32:0]   pts_reg;
    logic [13:0]   fsize_reg;
    logic [FW-1:0] drop_reg;
    logic [23:0]   rem_reg;
    logic [26:0]   quot_reg;
    logic [4:0]    div_cnt_reg;
    logic          m_tvalid_reg;

    logic [0:127] hb;
    logic         adts, latm, mode_eff, cfg_now, match;
    logic [4:0]   aot;
    logic [3:0]   lidx;
    logic [23:0]  latm_rate, new_rate, rate_fin;
    logic [3:0]   latm_ch, new_ch;
    logic [13:0]  fsize, ncount, dcount;
    logic [24:0]  rem_sh;
    logic         ge;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 8; j++) begin
                hb[8*i + j] = win_reg[i][7-j];
            end
        end
    end

    always_comb begin
        adts = (win_reg[0] == aalhp_pkg::ADTS_SYNC0) && (win_reg[1][7:4] == 4'hF);
        latm = (win_reg[0] == aalhp_pkg::LATM_SYNC0) && (win_reg[1][7:5] == 3'h7);
        mode_eff = mode_reg;
        if (detect_reg) begin
            if (!mode_reg && latm) mode_eff = 1'b1;
            else if (mode_reg && adts) mode_eff = 1'b0;
        end
        aot = hb[40 +: 5];
        if (aot == aalhp_pkg::AOT_ESCAPE) begin
            lidx = hb[51 +: 4];
            if (lidx == aalhp_pkg::RATE_IDX_EXPLICIT) begin
                latm_rate = hb[55 +: 24];
                latm_ch   = hb[79 +: 4];
            end else begin
                latm_rate = aalhp_pkg::rate_lookup(lidx);
                latm_ch   = hb[55 +: 4];
            end
        end else begin
            lidx = hb[45 +: 4];
            if (lidx == aalhp_pkg::RATE_IDX_EXPLICIT) begin
                latm_rate = hb[49 +: 24];
                latm_ch   = hb[73 +: 4];
            end else begin
                latm_rate = aalhp_pkg::rate_lookup(lidx);
                latm_ch   = hb[49 +: 4];
            end
        end
        cfg_now = 1'b0;
        if (!mode_eff) begin
            match    = adts;
            new_rate = aalhp_pkg::rate_lookup(hb[18 +: 4]);
            new_ch   = {1'b0, hb[23 +: 3]};
            fsize    = {1'b0, hb[30 +: 13]};
        end else begin
            cfg_now  = latm && !hb[24] && !hb[25];
            match    = latm && (cfg_now || configured_reg);
            new_rate = cfg_now ? latm_rate : rate_reg;
            new_ch   = cfg_now ? latm_ch : chan_reg;
            fsize    = {1'b0, hb[11 +: 13]} + 14'd3;
        end
        rate_fin = (new_rate == 24'd0) ? aalhp_pkg::DEFAULT_RATE : new_rate;
        ncount = (fsize == 14'd0) ? 14'd1 : fsize;
        dcount = (ncount > WIN14) ? WIN14 : ncount;
    end

    assign rem_sh = {rem_reg, quot_reg[26]};
    assign ge     = (rem_sh >= {1'b0, rate_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            skip_reg       <= '0;
            mode_reg       <= 1'b0;
            detect_reg     <= 1'b0;
            configured_reg <= 1'b0;
            rate_reg       <= '0;
            chan_reg       <= '0;
            pts_reg        <= '0;
            drop_reg       <= '0;
            div_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == aalhp_pkg::CFG_START_MODE) mode_reg <= cfg_data[0];
                else detect_reg <= cfg_data[0];
            end
            if (cmd.accept) begin
                if (in_pts_load) pts_reg <= in_pts_value;
                if (skip_reg != 14'd0) begin
                    skip_reg <= skip_reg - 14'd1;
                end else begin
                    win_reg[fill_reg[IW-1:0]] <= in_byte;
                    fill_reg <= fill_reg + FW'(1);
                end
            end
            if (cmd.check) begin
                mode_reg <= mode_eff;
                if (match) begin
                    rate_reg  <= rate_fin;
                    chan_reg  <= new_ch;
                    fsize_reg <= fsize;
                    if (cfg_now) configured_reg <= 1'b1;
                    drop_reg  <= dcount[FW-1:0];
                    skip_reg  <= ncount - dcount;
                end else begin
                    drop_reg  <= FW'(1);
                end
                rem_reg     <= '0;
                quot_reg    <= aalhp_pkg::DURATION_NUM;
                div_cnt_reg <= '0;
            end
            if (cmd.div_step) begin
                rem_reg     <= ge ? 24'(rem_sh - {1'b0, rate_reg}) : rem_sh[23:0];
                quot_reg    <= {quot_reg[25:0], ge};
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;
            if (cmd.load) begin
                m_tvalid_reg       <= 1'b1;
                out_frame_bytes    <= fsize_reg;
                out_sample_rate    <= rate_reg;
                out_channel_config <= chan_reg;
                out_frame_pts      <= pts_reg;
                out_frame_duration <= quot_reg;
                out_is_latm        <= mode_reg;
                pts_reg <= (pts_reg + {6'd0, quot_reg}) & aalhp_pkg::PTS_WRAP_MASK;
            end
            if (cmd.shift) begin
                for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WINDOW_BYTES-1] <= 8'd0;
                fill_reg <= fill_reg - FW'(1);
                drop_reg <= drop_reg - FW'(1);
            end
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign stat.need_check = (skip_reg == 14'd0) && (fill_reg == FILL_LAST);
    assign stat.match      = match;
    assign stat.div_done   = (div_cnt_reg == 5'(aalhp_pkg::DIV_STEPS));
    assign stat.out_free   = !m_tvalid_reg || m_tready;
    assign stat.drop_last  = (drop_reg == FW'(1));

endmodule
`default_nettype wire

FILE: rtl/aac_adts_latm_header_parser_unit.sv
// AAC ADTS/LATM frame header parser.
// The slave stream carries one elementary stream byte per transfer; tuser
// holds the timestamp load flag and tdata the byte and the new timestamp.
// The master stream carries one transfer per frame header found, with the
// frame size, sampling rate, channel configuration, timestamp and duration
// in tdata and the LATM flag in tuser.
// The byte that fills the look-ahead window starts a check: the head is
// tested, then on a miss one byte is dropped from the window; on a match
// the bit serial divider works out the duration in 27 steps, the output
// register is loaded once it is free, and the frame's bytes in the window
// are dropped (at most the window depth) and the rest of the frame skipped.
// The output register holds one result, so the next bytes are taken while a
// result waits; a header found while it is still full waits for it.
// Reset empties the window, clears the timestamp, stored configuration and
// skip count, and selects ADTS mode. Configuration writes take effect at
// once; index 0 also reloads the current mode.
`default_nettype none
module aac_adts_latm_header_parser_unit #(
    parameter int WINDOW_BYTES = aalhp_pkg::WINDOW_BYTES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [0:0]   cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [47:0]  s_tdata,   // data_byte, pts_value, zero fill
    input  wire logic [0:0]   s_tuser,   // pts_load
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // frame_bytes, sample_rate,
                                         // channel_config, frame_pts,
                                         // frame_duration, zero fill
    output logic [0:0]        m_tuser    // is_latm
);

    aalhp_pkg::cmd_t  cmd;
    aalhp_pkg::stat_t stat;
    logic [13:0] frame_bytes;
    logic [23:0] sample_rate;
    logic [3:0]  channel_config;
    logic [32:0] frame_pts;
    logic [26:0] frame_duration;
    logic        is_latm;

    aalhp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid),
        .s_tready(s_tready), .stat(stat), .cmd(cmd)
    );

    aalhp_dpath #(.WINDOW_BYTES(WINDOW_BYTES)) u_dpath (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_byte(s_tdata[7:0]), .in_pts_load(s_tuser[0]),
        .in_pts_value(s_tdata[40:8]),
        .cmd(cmd), .stat(stat), .m_tready(m_tready), .m_tvalid(m_tvalid),
        .out_frame_bytes(frame_bytes), .out_sample_rate(sample_rate),
        .out_channel_config(channel_config), .out_frame_pts(frame_pts),
        .out_frame_duration(frame_duration), .out_is_latm(is_latm)
    );

    assign m_tdata = {2'b00, frame_duration, frame_pts, channel_config,
                      sample_rate, frame_bytes};
    assign m_tuser = is_latm;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> stat.out_free) else $error("output loaded while full");
    a_miss_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.check && !stat.match) |=> cmd.shift) else $error("miss not dropped");
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.load)) else $error("result without load");

endmodule
`default_nettype wire
